// ===== sv/hgbs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the height grid bilinear sampler
// no dependencies
package hgbs_pkg;

  localparam logic [23:0] INV_CELL_WIDTH_RESET = 24'd65536;
  localparam logic [30:0] HALF_EXTENT_RESET    = 31'd8388608;
  localparam logic [15:0] NORMAL_ONE           = 16'sd16384;

  localparam logic CFG_INV_CELL_WIDTH = 1'b0;
  localparam logic CFG_HALF_EXTENT    = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_POS   = 10'b0000000010,
    ST_RANGE = 10'b0000000100,
    ST_READ  = 10'b0000001000,
    ST_ACC   = 10'b0000010000,
    ST_SQ    = 10'b0000100000,
    ST_SQRT  = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_OUT   = 10'b0100000000,
    ST_WAIT  = 10'b1000000000
  } state_t;

endpackage

// ===== sv/height_grid_bilinear_sampler_unit.sv =====
`timescale 1ns / 1ps
// height grid bilinear sampler: grid store, query sequencer, shared datapath
// depends on hgbs_pkg
//
// A write beat (kind 0) stores one grid point whose index lies inside the grid
// and gives no result. A query beat (kind 1) is handled by a sequencer around
// one shared 34x33 signed multiplier: the two position products, a range
// check, then 4 corner reads from the height and normal memories, 16
// multiplies for the weighted sums (four per corner: height, nx, ny, nz), 3
// squares, a 32-step bit-serial square root and three 17-step restoring
// divides with one setup step each. An out-of-range query skips from the range
// check to the output. The block takes no new beat while a query is in flight
// or while a finished result waits in the output register. The stores have no
// reset: corners never written read as anything.
module height_grid_bilinear_sampler_unit #(
  parameter int GRID_WIDTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // kind
  input  logic         s_tuser,
  // point_index[15:0], point_height[47:16], point_normal_x[63:48],
  // point_normal_y[79:64], point_normal_z[95:80], query_x[127:96],
  // query_z[159:128]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // in_range
  output logic         m_tuser,
  // height[31:0], normal_x[47:32], normal_y[63:48], normal_z[79:64]
  output logic [79:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int GW = GRID_WIDTH;
  localparam int CW = $clog2(GW);

  hgbs_pkg::state_t state;

  logic [23:0] inv_cell_width;
  logic [30:0] half_extent;

  // grid memories
  logic [31:0] height_mem [65536];
  logic [47:0] normal_mem [65536];
  logic [31:0] h_rd;
  logic [47:0] n_rd;
  logic [15:0] rd_addr;

  // query registers
  logic signed [32:0] sx, sz;
  logic signed [63:0] px, pz;
  logic [15:0] fa, fb;
  logic [CW-1:0] row, col;
  logic [2:0] corner;
  logic [1:0] comp;
  logic signed [65:0] hsum;
  logic signed [65:0] nsum [3];
  logic signed [45:0] nv [3];
  logic [63:0] sq;
  logic [5:0]  step;
  logic [31:0] root;
  logic [65:0] rem;
  logic [15:0] q;
  logic [63:0] dnum;
  logic [15:0] nout [3];
  logic signed [31:0] hout;
  logic [32:0] wgt;
  logic [32:0] wgt_next;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  assign mul_p = mul_a * mul_b;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == hgbs_pkg::ST_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_width <= hgbs_pkg::INV_CELL_WIDTH_RESET;
      half_extent    <= hgbs_pkg::HALF_EXTENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hgbs_pkg::CFG_INV_CELL_WIDTH: inv_cell_width <= cfg_data[23:0];
        hgbs_pkg::CFG_HALF_EXTENT:    half_extent <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == hgbs_pkg::KIND_WRITE &&
        ({16'd0, s_tdata[15:0]} < 32'(GW * GW))) begin
      height_mem[s_tdata[15:0]] <= s_tdata[47:16];
      normal_mem[s_tdata[15:0]] <= s_tdata[95:48];
    end
    h_rd <= height_mem[rd_addr];
    n_rd <= normal_mem[rd_addr];
  end

  // corner address, taken modulo the store depth
  logic [31:0] r_ext, c_ext;
  always_comb begin
    r_ext = 32'(row) + 32'(corner[1]);
    c_ext = 32'(col) + 32'(corner[0]);
    rd_addr = 16'(r_ext * 32'(GW) + c_ext);
  end

  // bilinear weight of the current corner (Q0.32, may be 2^32)
  always_comb begin
    logic [16:0] wa, wb;
    wa = corner[1] ? {1'b0, fa} : 17'd65536 - {1'b0, fa};
    wb = corner[0] ? {1'b0, fb} : 17'd65536 - {1'b0, fb};
    wgt_next = 33'(34'(wa) * 34'(wb));
  end

  // multiplier operand selection
  logic [15:0] ncomp;
  always_comb begin
    case (comp)
      2'd0: ncomp = n_rd[15:0];
      2'd1: ncomp = n_rd[31:16];
      2'd2: ncomp = n_rd[47:32];
      default: ncomp = '0;
    endcase
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      hgbs_pkg::ST_POS: begin
        mul_a = 34'(step[0] ? sz : sx);
        mul_b = 33'(signed'({1'b0, inv_cell_width}));
      end
      hgbs_pkg::ST_ACC: begin
        mul_a = signed'({1'b0, wgt});
        mul_b = (comp == 2'd3) ? 33'(signed'(h_rd)) : 33'(signed'(ncomp));
      end
      hgbs_pkg::ST_SQ: begin
        mul_a = 34'(nv[comp]);
        mul_b = 33'(nv[comp]);
      end
      default: ;
    endcase
  end

  // sqrt trial, two radicand bits a step from the top
  logic [65:0] sq_trial;
  logic [65:0] sq_rem_sh;
  always_comb begin
    sq_rem_sh = {rem[63:0], sq[63 - 2*step[4:0] -: 2]};
    sq_trial  = {32'd0, root, 2'b01};
  end

  logic [63:0] div_den;
  logic [64:0] div_sh;
  logic [63:0] div_init;
  always_comb begin
    div_den  = 64'({root, 1'b0});
    div_sh   = {rem[63:0], dnum[63]};
    div_init = 64'({nmag, 15'd0}) + 64'(root);
  end

  logic [45:0] nmag;
  assign nmag = nv[comp][45] ? 46'(-nv[comp]) : 46'(nv[comp]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hgbs_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        hgbs_pkg::ST_IDLE: begin
          if (s_tvalid && s_tready && s_tuser == hgbs_pkg::KIND_QUERY) begin
            sx    <= 33'(signed'(s_tdata[127:96])) + 33'(half_extent);
            sz    <= 33'(signed'(s_tdata[159:128])) + 33'(half_extent);
            step  <= '0;
            state <= hgbs_pkg::ST_POS;
          end
        end
        hgbs_pkg::ST_POS: begin
          if (step[0]) pz <= 64'(mul_p);
          else px <= 64'(mul_p);
          step <= step + 6'd1;
          if (step[0]) state <= hgbs_pkg::ST_RANGE;
        end
        hgbs_pkg::ST_RANGE: begin
          fa <= px[31:16];
          fb <= pz[31:16];
          row <= CW'(px[63:32]);
          col <= CW'(pz[63:32]);
          corner <= '0;
          comp <= 2'd3;
          hsum <= '0;
          for (int k = 0; k < 3; k++) nsum[k] <= '0;
          if (px[63] || pz[63] || px[63:32] >= 32'(GW - 1) ||
              pz[63:32] >= 32'(GW - 1)) begin
            m_tuser  <= 1'b0;
            hout     <= '0;
            nout[0]  <= '0;
            nout[1]  <= hgbs_pkg::NORMAL_ONE;
            nout[2]  <= '0;
            state    <= hgbs_pkg::ST_WAIT;
          end else begin
            state <= hgbs_pkg::ST_READ;
          end
        end
        hgbs_pkg::ST_READ: begin
          wgt   <= wgt_next;
          state <= hgbs_pkg::ST_ACC;
        end
        hgbs_pkg::ST_ACC: begin
          if (comp == 2'd3) hsum <= hsum + 66'(mul_p);
          else nsum[comp] <= nsum[comp] + 66'(mul_p);
          if (comp == 2'd2) begin
            if (corner == 3'd3) begin
              comp <= 2'd0;
              // floor of each blended component by 2^20
              for (int k = 0; k < 2; k++) nv[k] <= 46'(nsum[k] >>> 20);
              nv[2] <= 46'((nsum[2] + 66'(mul_p)) >>> 20);
              sq <= '0;
              state <= hgbs_pkg::ST_SQ;
            end else begin
              comp <= 2'd3;
              corner <= corner + 3'd1;
              state <= hgbs_pkg::ST_READ;
            end
          end else begin
            comp <= (comp == 2'd3) ? 2'd0 : comp + 2'd1;
          end
        end
        hgbs_pkg::ST_SQ: begin
          sq <= sq + mul_p[63:0];
          comp <= comp + 2'd1;
          if (comp == 2'd2) begin
            step <= '0;
            root <= '0;
            rem  <= '0;
            state <= hgbs_pkg::ST_SQRT;
          end
        end
        hgbs_pkg::ST_SQRT: begin
          if (sq_rem_sh >= sq_trial) begin
            rem  <= sq_rem_sh - sq_trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= sq_rem_sh;
            root <= {root[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            comp  <= 2'd0;
            step  <= '0;
            state <= hgbs_pkg::ST_DIV;
          end else begin
            step <= step + 6'd1;
          end
          hout <= 32'((hsum + 66'sh80000000) >>> 32);
          m_tuser <= 1'b1;
        end
        hgbs_pkg::ST_DIV: begin
          // quotient of (mag*32768 + len) / (2*len), one bit a step;
          // it stays below 2^17 so the top bits preload the remainder
          if (step == '0) begin
            rem  <= 66'(div_init >> 17);
            dnum <= div_init << 47;
            q    <= '0;
            step <= 6'd1;
          end else begin
            if (div_sh >= 65'(div_den)) begin
              rem <= 66'(div_sh - 65'(div_den));
              q <= {q[14:0], 1'b1};
            end else begin
              rem <= 66'(div_sh);
              q <= {q[14:0], 1'b0};
            end
            dnum <= {dnum[62:0], 1'b0};
            if (step == 6'd17) begin
              if (root == '0) nout[comp] <= '0;
              else nout[comp] <= nv[comp][45] ?
                16'(-{q, (div_sh >= 65'(div_den))}) :
                16'({q, (div_sh >= 65'(div_den))});
              step <= '0;
              comp <= comp + 2'd1;
              if (comp == 2'd2) state <= hgbs_pkg::ST_WAIT;
            end else begin
              step <= step + 6'd1;
            end
          end
        end
        hgbs_pkg::ST_WAIT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            state <= hgbs_pkg::ST_OUT;
          end
        end
        hgbs_pkg::ST_OUT: state <= hgbs_pkg::ST_IDLE;
        default: state <= hgbs_pkg::ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {nout[2], nout[1], nout[0], hout};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != hgbs_pkg::ST_IDLE) |-> !s_tready) else $error("ready while busy");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_range_norm: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (nout[1] == hgbs_pkg::NORMAL_ONE && hout == '0))
    else $error("bad out-of-range result");

endmodule
